// ===== hdl/sbb_pkg.sv =====
// Shared types and constants of the separable box blur core.
package sbb_pkg;

  localparam int RAD_W      = 5;
  localparam int OW_W       = 11;
  localparam int OH_W       = 14;
  localparam int AR_W       = 25;
  localparam int CH_W       = 16;
  localparam int NCH        = 4;
  localparam int HS_W       = 22;
  localparam int CS_W       = 28;
  localparam int POS_W      = 15;
  localparam int PROD_W     = CS_W + AR_W;
  localparam int RND_SHIFT  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [RAD_W-1:0] RADIUS_RST     = 5'd4;
  localparam logic [OW_W-1:0]  OUT_WIDTH_RST  = 11'd64;
  localparam logic [OH_W-1:0]  OUT_HEIGHT_RST = 14'd64;
  localparam logic [AR_W-1:0]  AREA_RECIP_RST = 25'd207126;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS     = 2'd0,
    CFG_OUT_WIDTH  = 2'd1,
    CFG_OUT_HEIGHT = 2'd2,
    CFG_AREA_RECIP = 2'd3
  } cfg_idx_t;

  typedef logic [CH_W-1:0] chan_t;
  typedef logic [HS_W-1:0] hsum_t;
  typedef logic [CS_W-1:0] csum_t;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [OW_W-1:0]  out_width;
    logic [OH_W-1:0]  out_height;
  } geom_t;

  typedef struct packed {
    logic wr;
    logic rd_line;
    logic rd_col;
    logic emit;
    logic eor;
    logic eof;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

  typedef struct packed {
    chan_t [NCH-1:0] ch;
    logic            eor;
    logic            eof;
  } result_t;

endpackage

// ===== hdl/sbb_if.sv =====
// Pixel and result channel interfaces of the box blur core.
interface sbb_in_if;
  logic           valid;
  logic           ready;
  sbb_pkg::chan_t in_red;
  sbb_pkg::chan_t in_green;
  sbb_pkg::chan_t in_blue;
  sbb_pkg::chan_t in_alpha;
  modport source(output valid, output in_red, output in_green, output in_blue,
                 output in_alpha, input ready);
  modport sink(input valid, input in_red, input in_green, input in_blue,
               input in_alpha, output ready);
endinterface

interface sbb_out_if;
  logic           valid;
  logic           ready;
  sbb_pkg::chan_t out_red;
  sbb_pkg::chan_t out_green;
  sbb_pkg::chan_t out_blue;
  sbb_pkg::chan_t out_alpha;
  logic           end_of_row;
  logic           end_of_frame;
  modport source(output valid, output out_red, output out_green, output out_blue,
                 output out_alpha, output end_of_row, output end_of_frame,
                 input ready);
  modport sink(input valid, input out_red, input out_green, input out_blue,
               input out_alpha, input end_of_row, input end_of_frame,
               output ready);
endinterface

// ===== hdl/separable_box_blur_rgba_core.sv =====
// Top level of the separable box blur core for premultiplied RGBA tiles.
//
// in_chan carries the padded tile in raster order, one pixel per item,
// padded by 2R on every side. out_chan carries one item per output pixel:
// the rounded, saturated box mean, with end_of_row and end_of_frame flags.
// Margin pixels give no result. cfg_we writes register cfg_index
// (radius, out_width, out_height, area_recip) and restarts the frame; write
// only while the core is idle.
// Throughput: one pixel per clock unless out_chan stalls. Horizontal sums are
// formed in the intake with one pixel delay line; column sums use one read and
// at most one write of the line store and column store per pixel, one port each.
// A result passes the intake queue, then the store read, column-sum and
// multiply registers; rounding feeds the result queue combinationally.
// Reset restores the register defaults and the start of a frame; the
// stores need no clearing pass. When out_chan stalls, results collect in an
// 8-entry queue, then a 4-entry queue ahead of the stores fills and
// in_chan.ready drops.
module separable_box_blur_rgba_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sbb_in_if.sink                           in_chan,
  sbb_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sbb_pkg::*;

  localparam int LINES = 2 * MAX_RADIUS + 1;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int LAW   = $clog2(LINES * MAX_WIDTH);
  localparam int QW    = TAG_W + NCH * HS_W + XW + LAW;
  localparam int Q_DEPTH = 4;

  geom_t            geom_r, geom_nxt;
  logic [AR_W-1:0]  area_recip_r, area_recip_nxt;

  chan_t [NCH-1:0]  in_px;
  logic             q_push, q_pop, q_full, q_empty;
  tag_t             f_tag, b_tag;
  hsum_t [NCH-1:0]  f_hs, b_hs;
  logic [XW-1:0]    f_x, b_x;
  logic [LAW-1:0]   f_laddr, b_laddr;
  logic [QW-1:0]    q_wdata, q_rdata;
  logic [$clog2(Q_DEPTH+1)-1:0] q_count;
  result_t          res;

  always_comb begin
    geom_nxt       = geom_r;
    area_recip_nxt = area_recip_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RADIUS:     geom_nxt.radius     = cfg_data[RAD_W-1:0];
        CFG_OUT_WIDTH:  geom_nxt.out_width  = cfg_data[OW_W-1:0];
        CFG_OUT_HEIGHT: geom_nxt.out_height = cfg_data[OH_W-1:0];
        CFG_AREA_RECIP: area_recip_nxt      = cfg_data[AR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.radius     <= RADIUS_RST;
      geom_r.out_width  <= OUT_WIDTH_RST;
      geom_r.out_height <= OUT_HEIGHT_RST;
      area_recip_r      <= AREA_RECIP_RST;
    end else begin
      geom_r       <= geom_nxt;
      area_recip_r <= area_recip_nxt;
    end
  end

  assign in_px[0] = in_chan.in_red;
  assign in_px[1] = in_chan.in_green;
  assign in_px[2] = in_chan.in_blue;
  assign in_px[3] = in_chan.in_alpha;

  sbb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (cfg_we),
    .geom     (geom_r),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_px    (in_px),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_tag    (f_tag),
    .q_hs     (f_hs),
    .q_x      (f_x),
    .q_laddr  (f_laddr)
  );

  assign q_wdata = {f_tag, f_hs, f_x, f_laddr};
  assign {b_tag, b_hs, b_x, b_laddr} = q_rdata;

  sbb_fifo #(.W(QW), .DEPTH(Q_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  sbb_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .area_recip (area_recip_r),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_tag      (b_tag),
    .q_hs       (b_hs),
    .q_x        (b_x),
    .q_laddr    (b_laddr),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_res    (res)
  );

  assign out_chan.out_red      = res.ch[0];
  assign out_chan.out_green    = res.ch[1];
  assign out_chan.out_blue     = res.ch[2];
  assign out_chan.out_alpha    = res.ch[3];
  assign out_chan.end_of_row   = res.eor;
  assign out_chan.end_of_frame = res.eof;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_count) <= Q_DEPTH)
    else $error("queue count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("item pushed into full queue");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !q_pop || $past(!q_empty))
    else $error("queue read after restart with no item");

endmodule

// ===== hdl/sbb_fifo.sv =====
// Small register queue with combinational head read.
module sbb_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4,
  localparam int PW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  wdata,
  input  logic          pop,
  output logic [W-1:0]  rdata,
  output logic          full,
  output logic          empty,
  output logic [CW-1:0] count
);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

// ===== hdl/sbb_front.sv =====
// Intake: raster position, horizontal running sums and item classification.
module sbb_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 16,
  localparam int LINES = 2 * MAX_RADIUS + 1,
  localparam int XW    = $clog2(MAX_WIDTH),
  localparam int LW    = $clog2(LINES),
  localparam int LAW   = $clog2(LINES * MAX_WIDTH)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 restart,
  input  sbb_pkg::geom_t                       geom,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sbb_pkg::chan_t [sbb_pkg::NCH-1:0]    in_px,
  input  logic                                 q_full,
  output logic                                 q_push,
  output sbb_pkg::tag_t                        q_tag,
  output sbb_pkg::hsum_t [sbb_pkg::NCH-1:0]    q_hs,
  output logic [XW-1:0]                        q_x,
  output logic [LAW-1:0]                       q_laddr
);
  import sbb_pkg::*;

  logic [XW-1:0]    x_r, x_nxt;
  logic [POS_W-1:0] y_r, y_nxt;
  logic [LW-1:0]    line_r, line_nxt;
  logic [LAW-1:0]   base_r, base_nxt;
  hsum_t [NCH-1:0]  acc_r;
  chan_t [NCH-1:0]  sh_r [LINES];

  logic [RAD_W-1:0] r_eff;
  logic [POS_W-1:0] r1, r2, r3, r4, pw, pw_raw, ph, ow, xe, u1, v1;
  chan_t [NCH-1:0]  tap;
  hsum_t [NCH-1:0]  hs;
  logic             accept;

  always_comb begin
    if (int'(geom.radius) > MAX_RADIUS) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = geom.radius;
    end
    r1     = POS_W'(r_eff);
    r2     = r1 << 1;
    r3     = r2 + r1;
    r4     = r1 << 2;
    pw_raw = POS_W'(geom.out_width) + r4;
    pw     = (pw_raw > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : pw_raw;
    if (pw == '0) begin
      pw = POS_W'(1);
    end
    ph = POS_W'(geom.out_height) + r4;
    if (ph == '0) begin
      ph = POS_W'(1);
    end
    ow = (pw > r4) ? pw - r4 : '0;
    xe = POS_W'(x_r);
    u1 = xe - r3 + POS_W'(1);
    v1 = y_r - r3 + POS_W'(1);
  end

  always_comb begin
    tap = sh_r[LW'(r2)];
    for (int c = 0; c < NCH; c++) begin
      hs[c] = ((x_r == '0) ? '0 : acc_r[c]) + HS_W'(in_px[c])
              - ((xe > r2) ? HS_W'(tap[c]) : '0);
    end
  end

  always_comb begin
    q_tag.wr      = (xe >= r2);
    q_tag.rd_line = (y_r > r2);
    q_tag.rd_col  = (y_r != '0);
    q_tag.emit    = (xe >= r3) && ((xe - r3) < ow) && (y_r >= r3) &&
                    ((y_r - r3) < POS_W'(geom.out_height));
    q_tag.eor     = (u1 == ow);
    q_tag.eof     = (u1 == ow) && (v1 == POS_W'(geom.out_height));
  end

  assign accept   = in_valid && !q_full;
  assign in_ready = !q_full;
  assign q_push   = accept;
  assign q_hs     = hs;
  assign q_x      = x_r;
  assign q_laddr  = base_r + LAW'(x_r);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    line_nxt = line_r;
    base_nxt = base_r;
    if (restart) begin
      x_nxt    = '0;
      y_nxt    = '0;
      line_nxt = '0;
      base_nxt = '0;
    end else if (accept) begin
      if (xe + POS_W'(1) >= pw) begin
        x_nxt = '0;
        if (y_r + POS_W'(1) >= ph) begin
          y_nxt    = '0;
          line_nxt = '0;
          base_nxt = '0;
        end else begin
          y_nxt = y_r + POS_W'(1);
          if (line_r == LW'(r2)) begin
            line_nxt = '0;
            base_nxt = '0;
          end else begin
            line_nxt = line_r + LW'(1);
            base_nxt = base_r + LAW'(MAX_WIDTH);
          end
        end
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      line_r <= '0;
      base_r <= '0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      line_r <= line_nxt;
      base_r <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r    <= hs;
      sh_r[0]  <= in_px;
      for (int i = 1; i < LINES; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

endmodule

// ===== hdl/sbb_back.sv =====
// Column sums over the line store, scaling, rounding and the result queue.
module sbb_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 16,
  localparam int LINES = 2 * MAX_RADIUS + 1,
  localparam int XW    = $clog2(MAX_WIDTH),
  localparam int LAW   = $clog2(LINES * MAX_WIDTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [sbb_pkg::AR_W-1:0]          area_recip,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  sbb_pkg::tag_t                     q_tag,
  input  sbb_pkg::hsum_t [sbb_pkg::NCH-1:0] q_hs,
  input  logic [XW-1:0]                     q_x,
  input  logic [LAW-1:0]                    q_laddr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sbb_pkg::result_t                  out_res
);
  import sbb_pkg::*;

  localparam int OF_DEPTH = 8;
  localparam int OF_CW    = $clog2(OF_DEPTH + 1);

  hsum_t [NCH-1:0] line_mem [LINES * MAX_WIDTH];
  csum_t [NCH-1:0] col_mem  [MAX_WIDTH];

  hsum_t [NCH-1:0] line_rd_r;
  csum_t [NCH-1:0] col_rd_r;

  logic            v1_r;
  tag_t            tag1_r;
  hsum_t [NCH-1:0] hs1_r;
  logic [XW-1:0]   x1_r;
  logic [LAW-1:0]  laddr1_r;

  logic            lw_v_r;
  logic [XW-1:0]   lw_x_r;
  logic [LAW-1:0]  lw_laddr_r;
  hsum_t [NCH-1:0] lw_hs_r;
  csum_t [NCH-1:0] lw_col_r;

  logic            v2_r;
  csum_t [NCH-1:0] cs2_r;
  logic            eor2_r, eof2_r;

  logic                          v3_r;
  logic [NCH-1:0][PROD_W-1:0]    prod3_r;
  logic                          eor3_r, eof3_r;

  hsum_t [NCH-1:0] line_old;
  csum_t [NCH-1:0] col_old;
  csum_t [NCH-1:0] col_new;
  logic            wr1;
  result_t         res3;
  logic [PROD_W-1:0]           rnd;
  logic [PROD_W-RND_SHIFT-1:0] quo;
  logic [OF_CW-1:0] of_count;
  logic             of_full, of_empty;
  logic [2:0]       inflight;

  assign inflight = 3'(v1_r) + 3'(v2_r) + 3'(v3_r);
  assign q_pop    = !q_empty && ((OF_CW + 1)'(of_count) + (OF_CW + 1)'(inflight)
                                 < (OF_CW + 1)'(OF_DEPTH));
  assign wr1      = v1_r && tag1_r.wr;

  always_comb begin
    line_old = (lw_v_r && (lw_laddr_r == laddr1_r)) ? lw_hs_r : line_rd_r;
    col_old  = (lw_v_r && (lw_x_r == x1_r)) ? lw_col_r : col_rd_r;
    for (int c = 0; c < NCH; c++) begin
      col_new[c] = (tag1_r.rd_col ? col_old[c] : '0) + CS_W'(hs1_r[c])
                   - (tag1_r.rd_line ? CS_W'(line_old[c]) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_rd_r <= line_mem[q_laddr];
      col_rd_r  <= col_mem[q_x];
    end
    if (wr1) begin
      line_mem[laddr1_r] <= hs1_r;
      col_mem[x1_r]      <= col_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      lw_v_r <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      v1_r   <= q_pop;
      lw_v_r <= wr1;
      v2_r   <= v1_r && tag1_r.emit;
      v3_r   <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tag1_r   <= q_tag;
      hs1_r    <= q_hs;
      x1_r     <= q_x;
      laddr1_r <= q_laddr;
    end
    lw_x_r     <= x1_r;
    lw_laddr_r <= laddr1_r;
    lw_hs_r    <= hs1_r;
    lw_col_r   <= col_new;
    cs2_r      <= col_new;
    eor2_r     <= tag1_r.eor;
    eof2_r     <= tag1_r.eof;
    for (int c = 0; c < NCH; c++) begin
      prod3_r[c] <= PROD_W'(cs2_r[c]) * PROD_W'(area_recip);
    end
    eor3_r <= eor2_r;
    eof3_r <= eof2_r;
  end

  always_comb begin
    rnd = '0;
    quo = '0;
    for (int c = 0; c < NCH; c++) begin
      rnd = prod3_r[c] + (PROD_W'(1) << (RND_SHIFT - 1));
      quo = rnd[PROD_W-1:RND_SHIFT];
      res3.ch[c] = (|quo[PROD_W-RND_SHIFT-1:CH_W]) ? '1 : quo[CH_W-1:0];
    end
    res3.eor = eor3_r;
    res3.eof = eof3_r;
  end

  sbb_fifo #(.W($bits(result_t)), .DEPTH(OF_DEPTH)) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (v3_r),
    .wdata (res3),
    .pop   (out_valid && out_ready),
    .rdata (out_res),
    .full  (of_full),
    .empty (of_empty),
    .count (of_count)
  );

  assign out_valid = !of_empty;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> !of_full)
    else $error("result pushed into full queue");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(of_count) + 32'(inflight)) <= OF_DEPTH)
    else $error("result credit exceeded");

  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> $past(v1_r && tag1_r.emit, 2))
    else $error("result without emitting item");

endmodule
